>>> src/gds_pkg.sv
// Package for the Gregorian date subtractor: item structs, operation codes,
// controller/datapath command and status structs, and calendar helpers.
// Depends on nothing; every other file imports it.
package gds_pkg;

	typedef struct packed {
		logic        [2:0]  operation;
		logic        [14:0] amount;
		logic        [4:0]  start_day;
		logic        [3:0]  start_month;
		logic signed [15:0] start_year;
	} request_t;

	typedef struct packed {
		logic        [4:0]  result_day;
		logic        [3:0]  result_month;
		logic signed [15:0] result_year;
	} result_t;

	localparam logic [2:0] OP_DAYS       = 3'd0;
	localparam logic [2:0] OP_WEEKS      = 3'd1;
	localparam logic [2:0] OP_MONTHS     = 3'd2;
	localparam logic [2:0] OP_YEARS      = 3'd3;
	localparam logic [2:0] OP_DECADES    = 3'd4;
	localparam logic [2:0] OP_CENTURIES  = 3'd5;
	localparam logic [2:0] OP_MILLENNIA  = 3'd6;

	// Reciprocal of 25 scaled by 2^21, rounded up; exact for 16-bit values.
	localparam logic [16:0] RECIP25       = 17'd83887;
	localparam int          RECIP25_SHIFT = 21;
	// 65535 mod 25: residue of the year 65535 (that is, -1).
	localparam logic [4:0]  WRAP_RES25    = 5'd10;
	// A negative year is divisible by 25 when its unsigned residue is this.
	localparam logic [4:0]  NEG_ZERO_RES25 = 5'd11;

	localparam logic [15:0] CENTURY    = 16'd100;
	localparam logic [15:0] MILLENNIUM = 16'd1000;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic load;
		logic mul;
		logic modr;
		logic norm;
		logic step_day;
		logic step_month;
	} gds_cmd_t;

	typedef struct packed {
		logic loop_days;
		logic loop_months;
		logic cnt_zero;
	} gds_sts_t;

	// Leap year test from the low bits and the unsigned residue mod 25.
	function automatic logic is_leap(input logic [15:0] y, input logic [4:0] r25);
		logic div4;
		logic div16;
		logic div25;
		div4  = (y[1:0] == 2'd0);
		div16 = (y[3:0] == 4'd0);
		div25 = y[15] ? (r25 == NEG_ZERO_RES25) : (r25 == 5'd0);
		return (div16 && div25) || (div4 && !div25);
	endfunction

	// Month length; m is 1 to 12.
	function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		len = MONTH_LEN[(m == 4'd0 || m > 4'd12) ? 4'd0 : 4'(m - 4'd1)];
		if (m == 4'd2 && leap) begin
			len = 5'd29;
		end
		return len;
	endfunction

endpackage

>>> src/gds_ctrl.sv
// Controller state machine of the Gregorian date subtractor.
// Sequences load, residue setup, normalization and the step loops; uses gds_pkg.
module gds_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  gds_pkg::gds_sts_t  sts,
	output gds_pkg::gds_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import gds_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_MOD,
		S_NORM,
		S_DAYS,
		S_MONTHS
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && start;
		cmd.mul        = (state_q == S_MUL);
		cmd.modr       = (state_q == S_MOD);
		cmd.norm       = (state_q == S_NORM);
		cmd.step_day   = (state_q == S_DAYS) && !sts.cnt_zero;
		cmd.step_month = (state_q == S_MONTHS) && !sts.cnt_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MUL;
						busy_q  <= 1'b1;
					end
				end
				S_MUL: state_q <= S_MOD;
				S_MOD: state_q <= S_NORM;
				S_NORM: begin
					if (sts.loop_days) begin
						state_q <= S_DAYS;
					end else if (sts.loop_months) begin
						state_q <= S_MONTHS;
					end else begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
					end
				end
				S_DAYS, S_MONTHS: begin
					if (sts.cnt_zero) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

>>> src/gds_dp.sv
// Datapath of the Gregorian date subtractor: date registers, step counter,
// year residue mod 25 and the day/month step logic; uses gds_pkg.
module gds_dp (
	input  logic               clk,
	input  gds_pkg::request_t  request,
	input  gds_pkg::gds_cmd_t  cmd,
	output gds_pkg::gds_sts_t  sts,
	output gds_pkg::result_t   result
);
	import gds_pkg::*;

	logic [2:0]  op_q;
	logic [14:0] amt_q;
	logic [4:0]  d_q;
	logic [3:0]  m_q;
	logic [15:0] y_q;
	logic [4:0]  r25_q;
	logic [17:0] cnt_q;
	logic [32:0] prod_q;

	logic [11:0] quot;
	logic [15:0] quot25;
	logic [4:0]  cur_len;
	logic [3:0]  m_prev;
	logic [15:0] y_prev;
	logic [4:0]  r25_prev;
	logic [4:0]  prev_len;
	logic [17:0] amt_x7;
	logic [15:0] amt_x10;

	assign quot   = prod_q[RECIP25_SHIFT +: 12];
	assign quot25 = {quot, 4'd0} + {1'b0, quot, 3'd0} + {4'd0, quot};

	assign cur_len = days_in(m_q, is_leap(y_q, r25_q));

	// Previous month, with the year and its residue stepped back in January.
	always_comb begin
		m_prev   = 4'(m_q - 4'd1);
		y_prev   = y_q;
		r25_prev = r25_q;
		if (m_q == 4'd1) begin
			m_prev   = 4'd12;
			y_prev   = 16'(y_q - 16'd1);
			if (y_q == 16'd0) begin
				r25_prev = WRAP_RES25;
			end else if (r25_q == 5'd0) begin
				r25_prev = 5'd24;
			end else begin
				r25_prev = 5'(r25_q - 5'd1);
			end
		end
	end

	assign prev_len = days_in(m_prev, is_leap(y_prev, r25_prev));
	assign amt_x7   = {amt_q, 3'd0} - {3'd0, amt_q};
	assign amt_x10  = 16'({amt_q, 3'd0} + {2'd0, amt_q, 1'b0});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= request.operation;
			amt_q <= request.amount;
			d_q   <= request.start_day;
			y_q   <= request.start_year;
			if (request.start_month == 4'd0) begin
				m_q <= 4'd1;
			end else if (request.start_month > 4'd12) begin
				m_q <= 4'd12;
			end else begin
				m_q <= request.start_month;
			end
		end
		if (cmd.mul) begin
			prod_q <= 33'(y_q) * 33'(RECIP25);
		end
		if (cmd.modr) begin
			r25_q <= 5'(y_q - quot25);
		end
		if (cmd.norm) begin
			if (d_q == 5'd0) begin
				d_q <= 5'd1;
			end else if (d_q > cur_len) begin
				d_q <= cur_len;
			end
			// The step counter is only read by the day and month loops.
			case (op_q) inside
				OP_DAYS, OP_MONTHS: cnt_q <= {3'd0, amt_q};
				OP_WEEKS:           cnt_q <= amt_x7;
				OP_YEARS:           y_q   <= y_q - {1'b0, amt_q};
				OP_DECADES:         y_q   <= y_q - amt_x10;
				OP_CENTURIES:       y_q   <= y_q - CENTURY;
				OP_MILLENNIA:       y_q   <= y_q - MILLENNIUM;
				default:            ;
			endcase
		end
		if (cmd.step_day) begin
			if (cnt_q >= {13'd0, d_q}) begin
				cnt_q <= cnt_q - {13'd0, d_q};
				m_q   <= m_prev;
				y_q   <= y_prev;
				r25_q <= r25_prev;
				d_q   <= prev_len;
			end else begin
				d_q   <= 5'(d_q - cnt_q[4:0]);
				cnt_q <= '0;
			end
		end
		if (cmd.step_month) begin
			cnt_q <= cnt_q - 18'd1;
			m_q   <= m_prev;
			y_q   <= y_prev;
			r25_q <= r25_prev;
			if (d_q > prev_len) begin
				d_q <= prev_len;
			end
		end
	end

	assign sts.loop_days   = (op_q == OP_DAYS) || (op_q == OP_WEEKS);
	assign sts.loop_months = (op_q == OP_MONTHS);
	assign sts.cnt_zero    = (cnt_q == 18'd0);

	assign result.result_day   = d_q;
	assign result.result_month = m_q;
	assign result.result_year  = y_q;

endmodule

>>> src/gregorian_date_subtractor_top.sv
// Top level of the Gregorian date subtractor.
// Instantiates gds_ctrl and gds_dp; uses gds_pkg for the item structs.
//
// Usage: the host drives an item on request (operation, amount, starting
// date) and raises start. The item is taken at a rising edge where start is
// high and busy is low; busy then stays high until the result is ready.
// The result appears on result together with a one-cycle done strobe and is
// taken at the edge that closes that cycle. The receiver cannot stall, so
// the host must sample result while done is high; result keeps its value
// until the next item is taken.
// Setup steps through S_MUL, S_MOD and S_NORM (year residue mod 25 by
// reciprocal multiply, then day normalization and year arithmetic), then
// the step loop runs. Year, decade, century and millennium items finish
// after S_NORM with no step loop. Month items step back one month per
// cycle until the count runs out. Day and week items step back one month
// boundary per cycle until the remaining days fall within the current
// month. One item is in flight at a time; the step loop through the shared
// date registers sets the rate.
// Reset (arst_n low) returns the controller to idle with busy and done low.
module gregorian_date_subtractor_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  gds_pkg::request_t request,
	output logic              busy,
	output logic              done,
	output gds_pkg::result_t  result
);
	import gds_pkg::*;

	gds_cmd_t cmd;
	gds_sts_t sts;

	// The controller owns the handshake and the step loop sequencing.
	gds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath holds the date under work and drives the result directly.
	gds_dp u_dp (
		.clk     (clk),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

endmodule
